@@ rtl/core/imsu_pkg.sv @@
// ----------------------------------------------------------------------------
// imsu_pkg
// Shared types, constants and helpers for the Ising Metropolis spin update.
// ----------------------------------------------------------------------------
`default_nettype none

package imsu_pkg;

  // Default lattice side and fixed field widths.
  localparam int SIDE_DEF  = 32;
  localparam int COORD_W   = 5;
  localparam int THR_W     = 16;
  localparam int LEVEL_W   = 4;
  localparam int MAG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int SEL_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR4  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR6  = 2'd3;

  // Request kinds.
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ATTEMPT = 1'b1;

  // Read selectors: the site itself and its six possible neighbors.
  localparam logic [SEL_W-1:0] SEL_CENTER = 3'd0;
  localparam logic [SEL_W-1:0] SEL_RP_C   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_RM_C   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_R_CP   = 3'd3;
  localparam logic [SEL_W-1:0] SEL_R_CM   = 3'd4;
  localparam logic [SEL_W-1:0] SEL_RM_CP  = 3'd5;
  localparam logic [SEL_W-1:0] SEL_RP_CM  = 3'd6;
  localparam logic [SEL_W-1:0] SEL_LAST   = 3'd6;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_item;
    logic             clear_step;
    logic             rd_issue;
    logic [SEL_W-1:0] rd_sel;
    logic             commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic req_type;
    logic out_busy;
  } status_t;

  // Reduce a coordinate modulo the side by repeated subtraction; for a side of
  // at least four, eight steps cover every five-bit value.
  function automatic logic [COORD_W-1:0] mod_side(input logic [COORD_W-1:0] v,
                                                  input logic [COORD_W:0]   side);
    logic [COORD_W:0] x;
    x = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (x >= side) begin
        x = x - side;
      end
    end
    return x[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/imsu_ram.sv @@
// ----------------------------------------------------------------------------
// imsu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imsu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/imsu_ctrl.sv @@
// ----------------------------------------------------------------------------
// imsu_ctrl
// Sequencer: clearing pass, neighbor read steps and commit of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module imsu_ctrl
  import imsu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t           state_r, state_nxt;
  logic [SEL_W-1:0] idx_r, idx_nxt;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= SEL_CENTER;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
          idx_nxt   = SEL_CENTER;
        end
      end
      ST_READ: begin
        if (status.req_type == REQ_LOAD || idx_r == SEL_LAST) begin
          state_nxt = ST_WAIT;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    cmd.rd_sel = idx_r;
    unique case (state_r)
      ST_CLEAR:  cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_READ:   cmd.rd_issue = 1'b1;
      ST_WAIT:   cmd.rd_issue = 1'b0;
      ST_COMMIT: cmd.commit = !status.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/imsu_dpath.sv @@
// ----------------------------------------------------------------------------
// imsu_dpath
// Datapath: spin RAM, neighbor sum, acceptance test, magnetization, output.
// ----------------------------------------------------------------------------
`default_nettype none

module imsu_dpath
  import imsu_pkg::*;
#(
  parameter int SIDE = SIDE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_wdata,
  input  wire logic                 in_req_type,
  input  wire logic [COORD_W-1:0]   in_row,
  input  wire logic [COORD_W-1:0]   in_col,
  input  wire logic                 in_load_spin,
  input  wire logic [THR_W-1:0]     in_random_u,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_flipped,
  output logic                      out_spin_now,
  output logic signed [LEVEL_W-1:0] out_energy_level,
  output logic signed [MAG_W-1:0]   out_magnetization
);

  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [COORD_W:0]   SIDE_C   = (COORD_W+1)'(SIDE);
  localparam logic [COORD_W-1:0] SIDE_M1  = COORD_W'(SIDE - 1);
  localparam logic [AW-1:0]      LAST_A   = AW'(DEPTH - 1);
  localparam logic signed [MAG_W-1:0] TOTAL_RST = MAG_W'(DEPTH);

  // Configuration registers.
  logic             shape_r;
  logic [THR_W-1:0] thr2_r, thr4_r, thr6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= 1'b0;
      thr2_r  <= '0;
      thr4_r  <= '0;
      thr6_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHAPE: shape_r <= cfg_wdata[0];
        CFG_THR2:  thr2_r  <= cfg_wdata;
        CFG_THR4:  thr4_r  <= cfg_wdata;
        CFG_THR6:  thr6_r  <= cfg_wdata;
        default:   shape_r <= shape_r;
      endcase
    end
  end

  // Latched item, with coordinates already reduced onto the lattice.
  logic               req_r, ld_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic [THR_W-1:0]   rnd_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_r <= in_req_type;
      row_r <= mod_side(in_row, SIDE_C);
      col_r <= mod_side(in_col, SIDE_C);
      ld_r  <= in_load_spin;
      rnd_r <= in_random_u;
    end
  end

  // Wrapped neighbor coordinates.
  logic [COORD_W-1:0] rp, rm, cp, cm;
  assign rp = (row_r == SIDE_M1) ? '0 : row_r + 5'd1;
  assign rm = (row_r == '0) ? SIDE_M1 : row_r - 5'd1;
  assign cp = (col_r == SIDE_M1) ? '0 : col_r + 5'd1;
  assign cm = (col_r == '0) ? SIDE_M1 : col_r - 5'd1;

  // Read address selection.
  logic [COORD_W-1:0] sr, sc;
  always_comb begin
    sr = row_r;
    sc = col_r;
    unique case (cmd.rd_sel)
      SEL_RP_C:  sr = rp;
      SEL_RM_C:  sr = rm;
      SEL_R_CP:  sc = cp;
      SEL_R_CM:  sc = cm;
      SEL_RM_CP: begin
        sr = rm;
        sc = cp;
      end
      SEL_RP_CM: begin
        sr = rp;
        sc = cm;
      end
      default: begin
        sr = row_r;
        sc = col_r;
      end
    endcase
  end

  logic [AW-1:0] raddr, site_addr;
  assign raddr     = AW'(AW'(sr) * AW'(SIDE) + AW'(sc));
  assign site_addr = AW'(AW'(row_r) * AW'(SIDE) + AW'(col_r));

  // Clearing pass counter.
  logic [AW-1:0] clr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Commit decision.
  logic                      center_r;
  logic signed [LEVEL_W-1:0] nsum_r;
  logic signed [LEVEL_W-1:0] level;
  logic                      flip;
  logic                      new_spin;

  always_comb begin
    level = center_r ? nsum_r : -nsum_r;
    flip  = 1'b0;
    priority if (level <= 0) begin
      flip = 1'b1;
    end else if (level == 4'sd2) begin
      flip = rnd_r < thr2_r;
    end else if (level == 4'sd4) begin
      flip = rnd_r < thr4_r;
    end else if (level == 4'sd6) begin
      flip = rnd_r < thr6_r;
    end else begin
      flip = 1'b0;
    end
    new_spin = (req_r == REQ_LOAD) ? ld_r : (center_r ^ flip);
  end

  // Spin RAM, written by the clearing pass or by a commit.
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr;
  assign ram_we    = cmd.clear_step || cmd.commit;
  assign ram_waddr = cmd.clear_step ? clr_r : site_addr;
  assign ram_wdata = cmd.clear_step ? 1'b1 : new_spin;

  imsu_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Capture of read data in the cycle after the read is issued.
  logic             capt_vld_r;
  logic [SEL_W-1:0] capt_sel_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capt_vld_r <= 1'b0;
    end else begin
      capt_vld_r <= cmd.rd_issue;
    end
    capt_sel_r <= cmd.rd_sel;
  end

  // Neighbor sum accumulation.
  logic signed [LEVEL_W-1:0] step_val;
  assign step_val = ram_rdata ? 4'sd1 : -4'sd1;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      nsum_r <= '0;
    end else if (capt_vld_r) begin
      if (capt_sel_r == SEL_CENTER) begin
        center_r <= ram_rdata;
      end else if (capt_sel_r == SEL_RM_CP || capt_sel_r == SEL_RP_CM) begin
        if (shape_r) begin
          nsum_r <= nsum_r + step_val;
        end
      end else begin
        nsum_r <= nsum_r + step_val;
      end
    end
  end

  // Magnetization total.
  logic signed [MAG_W-1:0] total_r, total_nxt;
  always_comb begin
    total_nxt = total_r;
    if (new_spin != center_r) begin
      total_nxt = new_spin ? total_r + 12'sd2 : total_r - 12'sd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RST;
    end else if (cmd.commit) begin
      total_r <= total_nxt;
    end
  end

  // Output register.
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_flipped       <= (req_r == REQ_ATTEMPT) && flip;
      out_spin_now      <= new_spin;
      out_energy_level  <= (req_r == REQ_ATTEMPT) ? level : '0;
      out_magnetization <= total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign status.clear_last = (clr_r == LAST_A);
  assign status.req_type   = req_r;
  assign status.out_busy   = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/core/ising_metropolis_spin_update.sv @@
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis spin update on a SIDE x SIDE periodic Ising lattice.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all SIDE*SIDE sites that
// sets every spin to +1; input is not taken during that pass, while
// configuration writes are. The lattice sits in a one-read, one-write RAM,
// so the site and its neighbors are read one per cycle: a load makes one read
// and a flip attempt seven, then come a wait state for the capture, a commit
// that holds while the output is full, and idle before the next beat is taken.
// A finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_spin_update
  import imsu_pkg::*;
#(
  parameter int SIDE = SIDE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_wdata,
  // Input stream.
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // in_tdata: site_row[4:0], site_col[9:5], load_spin[10], random_u[26:11]
  input  wire logic [31:0]          in_tdata,
  // in_tuser: req_type[0]
  input  wire logic                 in_tuser,
  // Output stream.
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // out_tdata: flipped[0], spin_now[1], energy_level[5:2], magnetization[17:6]
  output logic [23:0]               out_tdata
);

  cmd_t    cmd;
  status_t status;

  logic                      o_flipped, o_spin;
  logic signed [LEVEL_W-1:0] o_level;
  logic signed [MAG_W-1:0]   o_mag;

  imsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  imsu_dpath #(.SIDE(SIDE)) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_tuser),
    .in_row            (in_tdata[4:0]),
    .in_col            (in_tdata[9:5]),
    .in_load_spin      (in_tdata[10]),
    .in_random_u       (in_tdata[26:11]),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_flipped       (o_flipped),
    .out_spin_now      (o_spin),
    .out_energy_level  (o_level),
    .out_magnetization (o_mag)
  );

  // Pack the result beat.
  assign out_tdata = {6'd0, o_mag, o_level, o_spin, o_flipped};

endmodule

`default_nettype wire
